// File: rtl/hcbw_pkg.sv
// ----------------------------------------------------------------------------
// hcbw_pkg
// shared constants, types and slot helpers for the witness step pipeline
// ----------------------------------------------------------------------------
package hcbw_pkg;

   localparam int SLOTS_DEF = 8;
   localparam int MAX_SLOTS = 8;
   localparam int DEG_W = 2 * MAX_SLOTS;
   localparam int PAR_W = 3 * MAX_SLOTS;

   localparam logic [1:0] D_ABSENT = 2'd0;
   localparam logic [1:0] D_ZERO   = 2'd1;
   localparam logic [1:0] D_ONE    = 2'd2;
   localparam logic [1:0] D_TWO    = 2'd3;

   localparam logic [1:0] MODE_VTX  = 2'd0;
   localparam logic [1:0] MODE_EDGE = 2'd1;
   localparam logic [1:0] MODE_FGT  = 2'd2;
   localparam logic [1:0] MODE_JOIN = 2'd3;

   typedef struct packed {
      logic [DEG_W-1:0] deg;
      logic [PAR_W-1:0] par;
      logic             closed;
   } wit_type;

   // one pipeline word: working witness, join walk state and result control
   typedef struct packed {
      logic [1:0]         mode;
      wit_type            w;
      wit_type            w2;
      logic [MAX_SLOTS-1:0] used;
      logic               ok;
      logic               ext;
      wit_type            e;
   } stg_type;

   function automatic logic [1:0] dget(input wit_type w, input logic [2:0] k,
                                       input int slots);
      if (int'(k) >= slots) return D_ABSENT;
      return w.deg[2*k +: 2];
   endfunction

   function automatic logic [2:0] pget(input wit_type w, input logic [2:0] k,
                                       input int slots);
      if (int'(k) >= slots) return 3'd0;
      return w.par[3*k +: 3];
   endfunction

   function automatic wit_type dset(input wit_type w, input logic [2:0] k,
                                    input logic [1:0] v, input int slots);
      wit_type r;
      r = w;
      if (int'(k) < slots) r.deg[2*k +: 2] = v;
      return r;
   endfunction

   function automatic wit_type pset(input wit_type w, input logic [2:0] k,
                                    input logic [2:0] v, input int slots);
      wit_type r;
      r = w;
      if (int'(k) < slots) r.par[3*k +: 3] = v;
      return r;
   endfunction

   // edge (f,s) applied to an open path structure, ok cleared on rejection
   function automatic wit_type add_pair(input wit_type w, input logic [2:0] f,
                                        input logic [2:0] s, input int slots,
                                        output logic ok);
      wit_type    r;
      logic [1:0] df;
      logic [1:0] ds;
      logic [2:0] m1;
      logic [2:0] m2;
      r  = w;
      ok = 1'b1;
      df = dget(w, f, slots);
      ds = dget(w, s, slots);
      m1 = pget(w, f, slots);
      m2 = pget(w, s, slots);
      if (df == D_ABSENT || ds == D_ABSENT) begin
         ok = 1'b1;
      end else if (df == D_TWO || ds == D_TWO) begin
         ok = 1'b0;
      end else if (df == D_ZERO && ds == D_ZERO) begin
         r = dset(r, f, D_ONE, slots);
         r = dset(r, s, D_ONE, slots);
         r = pset(r, f, s, slots);
         r = pset(r, s, f, slots);
      end else if (df == D_ZERO) begin
         r = dset(r, f, D_ONE, slots);
         r = dset(r, s, D_TWO, slots);
         r = pset(r, f, m2, slots);
         r = pset(r, m2, f, slots);
      end else if (ds == D_ZERO) begin
         r = dset(r, s, D_ONE, slots);
         r = dset(r, f, D_TWO, slots);
         r = pset(r, s, m1, slots);
         r = pset(r, m1, s, slots);
      end else if (m1 == s) begin
         if (w.closed) ok = 1'b0;
         r.closed = 1'b1;
         r = dset(r, f, D_TWO, slots);
         r = dset(r, s, D_TWO, slots);
      end else begin
         r = dset(r, f, D_TWO, slots);
         r = dset(r, s, D_TWO, slots);
         r = pset(r, m1, m2, slots);
         r = pset(r, m2, m1, slots);
      end
      return r;
   endfunction

   // count of slots holding a degree code
   function automatic logic [4:0] count_code(input wit_type w, input logic [1:0] c,
                                             input int slots);
      logic [4:0] n;
      n = '0;
      for (int k = 0; k < MAX_SLOTS; k++)
         if (k < slots && w.deg[2*k +: 2] == c) n = n + 5'd1;
      return n;
   endfunction

endpackage

// File: rtl/hcbw_walk.sv
// ----------------------------------------------------------------------------
// hcbw_walk
// one registered step of the join pair walk: handles the pair at slot STEP
// ----------------------------------------------------------------------------
module hcbw_walk #(
   parameter int SLOTS = hcbw_pkg::SLOTS_DEF,
   parameter int STEP  = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  hcbw_pkg::stg_type in_stg,
   output logic              out_vld,
   output hcbw_pkg::stg_type out_stg
);
   import hcbw_pkg::*;

   localparam logic [2:0] K = 3'(STEP);

   logic    vld_ff;
   stg_type stg_ff;
   stg_type stg_in;

   // apply the pair that starts at this slot, join words only
   always_comb begin
      logic [2:0] s;
      logic       ok;
      wit_type    r;
      stg_in = in_stg;
      s  = pget(in_stg.w2, K, SLOTS);
      ok = 1'b1;
      r  = in_stg.w;
      if (in_stg.mode == MODE_JOIN && in_stg.ok && STEP < SLOTS &&
          !in_stg.used[STEP] && dget(in_stg.w2, K, SLOTS) == D_ONE) begin
         if (s == K) begin
            stg_in.ok = 1'b0;
         end else begin
            stg_in.used[STEP] = 1'b1;
            if (int'(s) < SLOTS) stg_in.used[s] = 1'b1;
            r = add_pair(in_stg.w, K, s, SLOTS, ok);
            stg_in.w  = r;
            stg_in.ok = ok;
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff <= stg_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_stg = stg_ff;

endmodule

// File: rtl/hamiltonian_cycle_bag_witness_step_top.sv
// ----------------------------------------------------------------------------
// hamiltonian_cycle_bag_witness_step_top
// witness transition pipeline for hamiltonian cycle tree-decomposition dp
// ----------------------------------------------------------------------------
// path from accepted request word to first response word: front stage, one walk
// stage per slot, check and output stages
// throughput: one request word per cycle while the receiver does not stall; an
// introduce-edge request with an extension gives two response words and holds
// the input while the output split stage sends the first of them
// reset: synchronous, clears all valid bits; payload registers are not reset
module hamiltonian_cycle_bag_witness_step_top #(
   parameter int SLOTS = hcbw_pkg::SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_mode,
   input  logic [2:0]             req_vertex_a,
   input  logic [2:0]             req_vertex_b,
   input  logic [15:0]            req_first_degrees,
   input  logic [23:0]            req_first_partners,
   input  logic                   req_first_closed,
   input  logic [15:0]            req_second_degrees,
   input  logic [23:0]            req_second_partners,
   input  logic                   req_second_closed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_out_degrees,
   output logic [23:0]            rsp_out_partners,
   output logic                   rsp_out_closed,
   output logic                   rsp_out_final,
   output logic                   rsp_last
);
   import hcbw_pkg::*;

   localparam int NST = MAX_SLOTS;

   logic    adv;
   logic    s0_vld_ff;
   stg_type s0_ff;
   stg_type s0_in;
   logic    w_vld [NST+1];
   stg_type w_stg [NST+1];
   logic    f_vld_ff;
   stg_type f_ff;
   stg_type f_in;
   logic    f_emit;
   logic    second_ff;
   logic    o_vld_ff;
   wit_type o_w_ff;
   logic    o_last_ff;
   logic    o_take;
   logic    o_free;

   // output slot free when empty or being taken this cycle
   assign o_free = !o_vld_ff || !rsp_stall;
   // a two-result word stays in the final stage until its second result is sent
   assign adv       = o_free && !(f_vld_ff && f_emit && f_ff.ext && !second_ff);
   assign req_stall = !adv;

   // front stage: decode mode, join pre-merge and introduce-edge extension
   always_comb begin
      wit_type w1;
      wit_type w2;
      wit_type e;
      logic [1:0] da;
      logic [1:0] db;
      logic ok;
      w1 = '{deg: req_first_degrees, par: req_first_partners, closed: req_first_closed};
      w2 = '{deg: req_second_degrees, par: req_second_partners, closed: req_second_closed};
      s0_in = '0;
      s0_in.mode = req_mode;
      s0_in.w    = w1;
      s0_in.w2   = w2;
      s0_in.e    = w1;
      e  = w1;
      ok = 1'b0;
      da = dget(w1, req_vertex_a, SLOTS);
      db = dget(w1, req_vertex_b, SLOTS);
      case (req_mode)
         MODE_VTX: begin
            s0_in.ok = int'(req_vertex_a) < SLOTS && da == D_ABSENT && !w1.closed;
            s0_in.w  = dset(w1, req_vertex_a, D_ZERO, SLOTS);
         end
         MODE_EDGE: begin
            s0_in.ok = 1'b1;
            if (!w1.closed && req_vertex_a != req_vertex_b &&
                int'(req_vertex_a) < SLOTS && int'(req_vertex_b) < SLOTS &&
                (da == D_ZERO || da == D_ONE) && (db == D_ZERO || db == D_ONE)) begin
               if (da == D_ONE && db == D_ONE &&
                   pget(w1, req_vertex_a, SLOTS) == req_vertex_b) begin
                  if (count_code(w1, D_ZERO, SLOTS) == 5'd0 &&
                      count_code(w1, D_ONE, SLOTS) == 5'd2) begin
                     e = dset(e, req_vertex_a, D_TWO, SLOTS);
                     e = dset(e, req_vertex_b, D_TWO, SLOTS);
                     e.closed = 1'b1;
                     ok = 1'b1;
                  end
               end else begin
                  e = add_pair(w1, req_vertex_a, req_vertex_b, SLOTS, ok);
               end
            end
            s0_in.ext = ok;
            s0_in.e   = e;
         end
         MODE_FGT: begin
            s0_in.ok = da == D_TWO;
            s0_in.w  = dset(w1, req_vertex_a, D_ABSENT, SLOTS);
         end
         default: begin
            s0_in.ok = !(w1.closed && w2.closed);
            s0_in.w.closed = w1.closed | w2.closed;
            for (int k = 0; k < MAX_SLOTS; k++) begin
               if (k < SLOTS && w2.deg[2*k +: 2] == D_TWO) begin
                  if (w1.deg[2*k +: 2] == D_ZERO) s0_in.w.deg[2*k +: 2] = D_TWO;
                  else if (w1.deg[2*k +: 2] != D_ABSENT) s0_in.ok = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
      end
   end

   assign w_vld[0] = s0_vld_ff;
   assign w_stg[0] = s0_ff;

   // pair walk, one slot per stage
   for (genvar g = 0; g < NST; g++) begin : g_walk
      hcbw_walk #(.SLOTS(SLOTS), .STEP(g)) u_walk (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .in_vld  (w_vld[g]),
         .in_stg  (w_stg[g]),
         .out_vld (w_vld[g+1]),
         .out_stg (w_stg[g+1])
      );
   end

   // final check stage: closed join must leave no degree 0 or 1 slot
   always_comb begin
      f_in = w_stg[NST];
      if (f_in.mode == MODE_JOIN && f_in.w.closed &&
          (count_code(f_in.w, D_ZERO, SLOTS) != 5'd0 ||
           count_code(f_in.w, D_ONE, SLOTS) != 5'd0))
         f_in.ok = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= w_vld[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   assign f_emit = f_ff.ok;

   // second result pending flag for extended edge words
   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else if (o_free) begin
         second_ff <= f_vld_ff && f_emit && f_ff.ext && !second_ff;
      end
   end

   // output register, unused slots and non-degree-1 partners cleared
   assign o_take = f_vld_ff && f_emit && o_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (o_free) begin
         o_vld_ff <= o_take;
      end
   end

   always_ff @(posedge clock) begin
      wit_type src;
      src = second_ff ? f_ff.e : f_ff.w;
      if (o_take) begin
         for (int k = 0; k < MAX_SLOTS; k++) begin
            if (k >= SLOTS) src.deg[2*k +: 2] = D_ABSENT;
            if (src.deg[2*k +: 2] != D_ONE) src.par[3*k +: 3] = 3'd0;
         end
         o_w_ff    <= src;
         o_last_ff <= second_ff || !f_ff.ext;
      end
   end

   assign rsp_valid        = o_vld_ff;
   assign rsp_out_degrees  = o_w_ff.deg;
   assign rsp_out_partners = o_w_ff.par;
   assign rsp_out_closed   = o_w_ff.closed;
   assign rsp_out_final    = o_w_ff.closed &&
                             count_code(o_w_ff, D_ZERO, SLOTS) == 5'd0 &&
                             count_code(o_w_ff, D_ONE, SLOTS) == 5'd0;
   assign rsp_last         = o_last_ff;

   // checks
   a_second_needs_ext: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> f_vld_ff && f_ff.ext)
      else $error("second result without extension");
   a_hold_on_split: assert property (@(posedge clock) disable iff (reset)
      (f_vld_ff && f_emit && f_ff.ext && !second_ff) |-> req_stall)
      else $error("pipeline moved during split");
   a_second_last: assert property (@(posedge clock) disable iff (reset)
      (o_free && second_ff && f_vld_ff) |=> (o_vld_ff && o_last_ff))
      else $error("second result not last");

endmodule

// File: tb/hamiltonian_cycle_bag_witness_step_top_tb.sv
// ----------------------------------------------------------------------------
// hamiltonian_cycle_bag_witness_step_top_tb
// drives witness transitions through the step pipeline and checks every
// result word against an in-bench witness predictor, with random idling
// ----------------------------------------------------------------------------
module hamiltonian_cycle_bag_witness_step_top_tb;
   import hcbw_pkg::*;

   localparam int NSLOT = 8;
   localparam int CYCLE_LIMIT = 200000;

   // one predicted result word
   typedef struct {
      logic [15:0] deg;
      logic [23:0] par;
      logic        closed;
      logic        fin;
      logic        last;
   } witness_word_type;

   // working witness used by the predictor
   typedef struct {
      logic [15:0] deg;
      logic [23:0] par;
      logic        closed;
   } witness_type;

   int fail_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   // witness transition predictor
   function automatic logic [1:0] deg_at(witness_type w, int k);
      if (k >= NSLOT) return D_ABSENT;
      return w.deg[2*k +: 2];
   endfunction

   function automatic logic [2:0] partner_at(witness_type w, int k);
      if (k >= NSLOT) return 3'd0;
      return w.par[3*k +: 3];
   endfunction

   function automatic void put_deg(ref witness_type w, input int k, input logic [1:0] v);
      if (k < NSLOT) w.deg[2*k +: 2] = v;
   endfunction

   function automatic void put_partner(ref witness_type w, input int k, input logic [2:0] v);
      if (k < NSLOT) w.par[3*k +: 3] = v;
   endfunction

   function automatic int degree_count(witness_type w, logic [1:0] c);
      int n;
      n = 0;
      for (int k = 0; k < NSLOT; k++) if (deg_at(w, k) == c) n++;
      return n;
   endfunction

   function automatic witness_word_type pack_word(witness_type w, logic last);
      witness_word_type o;
      o.deg = '0;
      o.par = '0;
      for (int k = 0; k < NSLOT; k++) begin
         o.deg[2*k +: 2] = deg_at(w, k);
         if (deg_at(w, k) == D_ONE) o.par[3*k +: 3] = partner_at(w, k);
      end
      o.closed = w.closed;
      o.fin = (degree_count(w, D_ZERO) == 0 && degree_count(w, D_ONE) == 0 && w.closed);
      o.last = last;
      return o;
   endfunction

   // link slots f and s in the path structure; zero on rejection
   function automatic bit link_ends(ref witness_type w, input int f, input int s);
      logic [1:0] df, ds;
      logic [2:0] m1, m2;
      df = deg_at(w, f);
      ds = deg_at(w, s);
      if (df == D_ABSENT || ds == D_ABSENT) return 1;
      if (df == D_TWO || ds == D_TWO) return 0;
      if (df == D_ZERO && ds == D_ZERO) begin
         put_deg(w, f, D_ONE); put_deg(w, s, D_ONE);
         put_partner(w, f, 3'(s)); put_partner(w, s, 3'(f));
      end else if (df == D_ZERO) begin
         m2 = partner_at(w, s);
         put_deg(w, f, D_ONE); put_deg(w, s, D_TWO);
         put_partner(w, f, m2); put_partner(w, int'(m2), 3'(f));
      end else if (ds == D_ZERO) begin
         m1 = partner_at(w, f);
         put_deg(w, s, D_ONE); put_deg(w, f, D_TWO);
         put_partner(w, s, m1); put_partner(w, int'(m1), 3'(s));
      end else begin
         m1 = partner_at(w, f);
         m2 = partner_at(w, s);
         if (m1 == s) begin
            if (w.closed) return 0;
            w.closed = 1;
            put_deg(w, f, D_TWO); put_deg(w, s, D_TWO);
         end else begin
            put_deg(w, f, D_TWO); put_deg(w, s, D_TWO);
            put_partner(w, int'(m1), m2); put_partner(w, int'(m2), m1);
         end
      end
      return 1;
   endfunction

   // scoreboard of expected result words
   class witness_scoreboard;
      witness_word_type pending[$];

      function void note_request(logic [1:0] mode, int a, int b, witness_type w1,
                                 witness_type w2);
         witness_type e, p;
         bit ext, used [NSLOT];
         logic [1:0] da, db, d1, d2;
         int s;
         case (mode)
            MODE_VTX: begin
               if (a < NSLOT && deg_at(w1, a) == D_ABSENT && !w1.closed) begin
                  put_deg(w1, a, D_ZERO);
                  pending.push_back(pack_word(w1, 1'b1));
               end
            end
            MODE_EDGE: begin
               e = w1;
               ext = 0;
               da = deg_at(w1, a);
               db = deg_at(w1, b);
               if (!w1.closed && a != b && a < NSLOT && b < NSLOT &&
                   (da == D_ZERO || da == D_ONE) && (db == D_ZERO || db == D_ONE)) begin
                  if (da == D_ONE && db == D_ONE && partner_at(w1, a) == b) begin
                     if (degree_count(w1, D_ZERO) == 0 && degree_count(w1, D_ONE) == 2) begin
                        put_deg(e, a, D_TWO); put_deg(e, b, D_TWO);
                        e.closed = 1;
                        ext = 1;
                     end
                  end else begin
                     ext = link_ends(e, a, b);
                  end
               end
               pending.push_back(pack_word(w1, !ext));
               if (ext) pending.push_back(pack_word(e, 1'b1));
            end
            MODE_FGT: begin
               if (deg_at(w1, a) == D_TWO) begin
                  put_deg(w1, a, D_ABSENT);
                  pending.push_back(pack_word(w1, 1'b1));
               end
            end
            default: begin
               if (w1.closed && w2.closed) return;
               p = w1;
               p.closed = w1.closed | w2.closed;
               for (int k = 0; k < NSLOT; k++) begin
                  d1 = deg_at(w1, k);
                  d2 = deg_at(w2, k);
                  if (d2 == D_TWO) begin
                     if (d1 == D_ZERO) put_deg(p, k, D_TWO);
                     else if (d1 != D_ABSENT) return;
                  end
                  used[k] = 0;
               end
               for (int k = 0; k < NSLOT; k++) begin
                  if (used[k] || deg_at(w2, k) != D_ONE) continue;
                  s = int'(partner_at(w2, k));
                  if (s == k) return;
                  used[k] = 1;
                  if (s < NSLOT) used[s] = 1;
                  if (!link_ends(p, k, s)) return;
               end
               if (p.closed && (degree_count(p, D_ZERO) != 0 || degree_count(p, D_ONE) != 0))
                  return;
               pending.push_back(pack_word(p, 1'b1));
            end
         endcase
      endfunction

      task check_word(witness_word_type got);
         witness_word_type want;
         if (pending.size() == 0) begin
            report_mismatch("result word with nothing expected");
            return;
         end
         want = pending.pop_front();
         if (got.deg !== want.deg)
            report_mismatch($sformatf("degrees %h want %h", got.deg, want.deg));
         if (got.par !== want.par)
            report_mismatch($sformatf("partners %h want %h", got.par, want.par));
         if (got.closed !== want.closed)
            report_mismatch($sformatf("closed %b want %b", got.closed, want.closed));
         if (got.fin !== want.fin)
            report_mismatch($sformatf("final %b want %b", got.fin, want.fin));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b want %b", got.last, want.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [2:0]  req_vertex_a = '0;
   logic [2:0]  req_vertex_b = '0;
   logic [15:0] req_first_degrees = '0;
   logic [23:0] req_first_partners = '0;
   logic        req_first_closed = 0;
   logic [15:0] req_second_degrees = '0;
   logic [23:0] req_second_partners = '0;
   logic        req_second_closed = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [15:0] rsp_out_degrees;
   logic [23:0] rsp_out_partners;
   logic        rsp_out_closed;
   logic        rsp_out_final;
   logic        rsp_last;

   witness_scoreboard board = new();
   int  cycle_count = 0;
   bit  hold_off = 0;
   bit  stim_done = 0;

   hamiltonian_cycle_bag_witness_step_top dut (.*);

   always #1 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // note accepted request words
   always @(posedge clock) begin
      witness_type w1, w2;
      if (!reset && req_valid && !req_stall) begin
         w1.deg = req_first_degrees; w1.par = req_first_partners;
         w1.closed = req_first_closed;
         w2.deg = req_second_degrees; w2.par = req_second_partners;
         w2.closed = req_second_closed;
         board.note_request(req_mode, int'(req_vertex_a), int'(req_vertex_b), w1, w2);
      end
   end

   // check accepted result words
   always @(posedge clock) begin
      witness_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.deg = rsp_out_degrees; got.par = rsp_out_partners;
         got.closed = rsp_out_closed; got.fin = rsp_out_final; got.last = rsp_last;
         board.check_word(got);
      end
   end

   // receiver stall pattern, with a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1;
      else if (hold_off) rsp_stall <= 1;
      else if (cycle_count % 512 < 128) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // random witness; when shaped, well-formed: degrees chosen, partners paired between degree-1 slots
   function automatic void make_witness(output logic [15:0] deg, output logic [23:0] par,
                                        input bit shaped);
      int ones[$];
      int j;
      logic [2:0] t;
      deg = 16'($urandom());
      par = 24'($urandom());
      if (!shaped) return;
      par = '0;
      for (int k = 0; k < NSLOT; k++)
         if (deg[2*k +: 2] == D_ONE) ones.push_back(k);
      if (ones.size() % 2 == 1) begin
         deg[2*ones[$] +: 2] = D_TWO;
         void'(ones.pop_back());
      end
      ones.shuffle();
      for (j = 0; j + 1 < ones.size(); j += 2) begin
         t = 3'(ones[j + 1]);
         par[3*ones[j] +: 3] = t;
         t = 3'(ones[j]);
         par[3*ones[j + 1] +: 3] = t;
      end
   endfunction

   // offer one request word and wait until it is taken
   task automatic send_request(input logic [1:0] mode, input logic [2:0] a, input logic [2:0] b,
                               input logic [15:0] d1, input logic [23:0] p1, input logic c1,
                               input logic [15:0] d2, input logic [23:0] p2, input logic c2);
      req_valid <= 1;
      req_mode <= mode; req_vertex_a <= a; req_vertex_b <= b;
      req_first_degrees <= d1; req_first_partners <= p1; req_first_closed <= c1;
      req_second_degrees <= d2; req_second_partners <= p2; req_second_closed <= c2;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_random(input bit shaped);
      logic [15:0] d1, d2;
      logic [23:0] p1, p2;
      logic [1:0]  mode;
      logic        c1, c2;
      make_witness(d1, p1, shaped);
      make_witness(d2, p2, shaped);
      mode = 2'($urandom_range(0, 3));
      c1 = ($urandom_range(0, 4) == 0);
      c2 = ($urandom_range(0, 4) == 0);
      // joins with disjoint degree-2 sets get past the first check more often
      if (shaped && mode == MODE_JOIN)
         for (int k = 0; k < NSLOT; k++)
            if (d2[2*k +: 2] == D_TWO && d1[2*k +: 2] != D_ZERO && $urandom_range(0, 1))
               d2[2*k +: 2] = D_ZERO;
      send_request(mode, 3'($urandom()), 3'($urandom()), d1, p1, c1, d2, p2, c2);
   endtask

   // long receiver hold-off while the sender keeps offering
   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off <= 1;
      repeat (150) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      int burst;
      int settle;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: vertex introduce, forget, highest slot, closed witness
      send_request(MODE_VTX, 3'd0, 3'd0, 16'h0000, '0, 1'b0, '0, '0, 1'b0);
      send_request(MODE_VTX, 3'd7, 3'd0, 16'h0000, '0, 1'b1, '0, '0, 1'b0);
      send_request(MODE_VTX, 3'd7, 3'd0, 16'hFFFF, 24'hFFFFFF, 1'b0, '0, '0, 1'b0);
      send_request(MODE_FGT, 3'd7, 3'd0, 16'hC000, '0, 1'b0, '0, '0, 1'b0);
      send_request(MODE_FGT, 3'd1, 3'd0, 16'h0004, '0, 1'b0, '0, '0, 1'b0);
      // edges: 0-0, 0-1, 1-1 joining paths, self edge, closing the cycle
      send_request(MODE_EDGE, 3'd0, 3'd1, 16'h0005, '0, 1'b0, '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd2, 3'd0, 16'h001E, 24'h000008, 1'b0, '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd1, 3'd2, 16'h00AA, 24'h0008C1 | 24'h002000, 1'b0,
                   '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd3, 3'd3, 16'h00FF, '0, 1'b0, '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd0, 3'd1, 16'hFFFA, 24'h000001 | 24'h000000, 1'b0,
                   '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd0, 3'd1, 16'h000A, 24'h000001, 1'b0, '0, '0, 1'b0);
      send_request(MODE_EDGE, 3'd0, 3'd1, 16'h000A, 24'h000001, 1'b1, '0, '0, 1'b0);
      // joins: degree 0 meets 2, rejected overuse, self-paired, both closed, closing pair
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h0005, '0, 1'b0, 16'h000F, '0, 1'b0);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h000E, '0, 1'b0, 16'h000C, '0, 1'b0);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h0005, '0, 1'b0, 16'h0002, '0, 1'b0);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h000F, '0, 1'b1, 16'h0000, '0, 1'b1);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h000A, 24'h000001, 1'b0,
                   16'h000A, 24'h000001, 1'b0);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h0000, '0, 1'b0, 16'h000A, 24'h000001, 1'b1);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'hFFFF, 24'hFFFFFF, 1'b0,
                   16'hAAAA, 24'hFFFFFF, 1'b0);
      send_request(MODE_JOIN, 3'd0, 3'd0, 16'h0000, '0, 1'b0, 16'h0000, '0, 1'b0);

      // random bursts, mostly well-formed witnesses
      for (int n = 0; n < 600; ) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++, n++) send_random($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      req_valid <= 0;

      // drain
      while (board.pending.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 4 * NSLOT + 20) begin
         @(posedge clock);
         settle++;
      end
      if (fail_count == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
